/* hw/rtl/csmc_pkg.sv */
package csmc_pkg;

  localparam logic [7:0] WP_ADDR  = 8'h8e;
  localparam logic [7:0] WP_OFF   = 8'h00;
  localparam logic [7:0] WP_ON    = 8'h80;
  localparam logic [7:0] A_SEC    = 8'h80;
  localparam logic [7:0] A_MIN    = 8'h82;
  localparam logic [7:0] A_HOUR   = 8'h84;
  localparam logic [7:0] A_DAY    = 8'h86;
  localparam logic [7:0] A_MONTH  = 8'h88;
  localparam logic [7:0] A_WDAY   = 8'h8a;
  localparam logic [7:0] A_YEAR   = 8'h8c;
  localparam logic [7:0] A_AHOUR  = 8'hc0;
  localparam logic [7:0] A_AMIN   = 8'hfc;

  localparam int MAX_WRITES = 9;
  localparam int IDX_W      = $clog2(MAX_WRITES);

  typedef enum logic [2:0] {
    FUNC_SET     = 3'd0,
    FUNC_ADJUST  = 3'd1,
    FUNC_CONFIRM = 3'd2,
    FUNC_ALARM   = 3'd3,
    FUNC_REFRESH = 3'd4,
    FUNC_ALOAD   = 3'd5
  } func_t;

  typedef struct packed {
    logic                             has_write;
    logic [IDX_W-1:0]                 last_idx;
    logic [MAX_WRITES-1:0][7:0]       addr;
    logic [MAX_WRITES-1:0][7:0]       data;
    logic [2:0]                       time_stage;
    logic [1:0]                       alarm_stage;
    logic                             alarm_hit;
  } job_t;

  function automatic logic [7:0] inc_sixty(input logic [7:0] v);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [8:0] sum;
    lo = {1'b0, v[3:0]} + 5'd1;
    hi = {1'b0, v[7:4]};
    if (lo == 5'd10) begin
      lo = 5'd0;
      hi = hi + 5'd1;
      if (hi >= 5'd6) begin
        hi = 5'd0;
      end
    end
    sum = {hi, 4'b0000} + {4'b0000, lo};
    return sum[7:0];
  endfunction

  function automatic logic [7:0] inc_capped(input logic [7:0] v, input logic [4:0] cap_hi,
                                            input logic [4:0] cap_lo,
                                            input logic [4:0] restart);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [8:0] sum;
    lo = {1'b0, v[3:0]} + 5'd1;
    hi = {1'b0, v[7:4]};
    if (hi >= cap_hi && lo >= cap_lo) begin
      lo = restart;
      hi = 5'd0;
    end
    if (lo == 5'd10) begin
      lo = 5'd0;
      hi = hi + 5'd1;
    end
    sum = {hi, 4'b0000} + {4'b0000, lo};
    return sum[7:0];
  endfunction

endpackage

/* hw/rtl/csmc_front.sv */
module csmc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [2:0]          func,
  input  logic [7:0]          sec,
  input  logic [7:0]          minute,
  input  logic [7:0]          hour,
  input  logic [7:0]          day,
  input  logic [7:0]          month,
  input  logic [7:0]          weekday,
  input  logic [7:0]          year,
  output csmc_pkg::job_t      job
);

  logic [7:0] clock_sec, clock_min, clock_hour, clock_day, clock_month;
  logic [7:0] clock_weekday, clock_year, alarm_hour_value, alarm_min_value;
  logic [2:0] time_step;
  logic [1:0] alarm_step;

  logic [7:0] clock_sec_next, clock_min_next, clock_hour_next, clock_day_next;
  logic [7:0] clock_month_next, clock_weekday_next, clock_year_next;
  logic [7:0] alarm_hour_value_next, alarm_min_value_next;
  logic [2:0] time_step_next;
  logic [1:0] alarm_step_next;
  logic [7:0] wday_inc;

  function automatic csmc_pkg::job_t guarded(input csmc_pkg::job_t j, input logic [7:0] a,
                                             input logic [7:0] d);
    csmc_pkg::job_t r;
    r = j;
    r.has_write = 1'b1;
    r.last_idx  = csmc_pkg::IDX_W'(2);
    r.addr[0]   = csmc_pkg::WP_ADDR;
    r.data[0]   = csmc_pkg::WP_OFF;
    r.addr[1]   = a;
    r.data[1]   = d;
    r.addr[2]   = csmc_pkg::WP_ADDR;
    r.data[2]   = csmc_pkg::WP_ON;
    return r;
  endfunction

  always_comb begin
    clock_sec_next        = clock_sec;
    clock_min_next        = clock_min;
    clock_hour_next       = clock_hour;
    clock_day_next        = clock_day;
    clock_month_next      = clock_month;
    clock_weekday_next    = clock_weekday;
    clock_year_next       = clock_year;
    alarm_hour_value_next = alarm_hour_value;
    alarm_min_value_next  = alarm_min_value;
    time_step_next        = time_step;
    alarm_step_next       = alarm_step;
    job                   = '0;
    wday_inc              = clock_weekday + 8'd1;

    case (func)
      csmc_pkg::FUNC_SET: begin
        if (alarm_step == 2'd0) begin
          time_step_next = time_step + 3'd1;
          case (time_step)
            3'd1: job = guarded(job, csmc_pkg::A_SEC, clock_sec);
            3'd2: job = guarded(job, csmc_pkg::A_MIN, clock_min);
            3'd3: job = guarded(job, csmc_pkg::A_MONTH, clock_month);
            3'd4: job = guarded(job, csmc_pkg::A_HOUR, clock_hour);
            3'd5: job = guarded(job, csmc_pkg::A_DAY, clock_day);
            3'd6: job = guarded(job, csmc_pkg::A_YEAR, clock_year);
            3'd7: job = guarded(job, csmc_pkg::A_WDAY, clock_weekday);
            default: ;
          endcase
        end
      end
      csmc_pkg::FUNC_ADJUST: begin
        if (time_step != 3'd0 && alarm_step == 2'd0) begin
          case (time_step)
            3'd1: clock_sec_next = csmc_pkg::inc_sixty(clock_sec);
            3'd2: clock_min_next = csmc_pkg::inc_sixty(clock_min);
            3'd3: clock_hour_next = csmc_pkg::inc_capped(clock_hour, 5'd2, 5'd4, 5'd0);
            3'd4: clock_weekday_next = (wday_inc == 8'd8) ? 8'd1 : wday_inc;
            3'd5: clock_day_next = csmc_pkg::inc_capped(clock_day, 5'd3, 5'd1, 5'd1);
            3'd6: clock_month_next = csmc_pkg::inc_capped(clock_month, 5'd1, 5'd3, 5'd1);
            3'd7: clock_year_next = csmc_pkg::inc_capped(clock_year, 5'd2, 5'd1, 5'd1);
            default: ;
          endcase
        end else if (alarm_step != 2'd0 && time_step == 3'd0) begin
          if (alarm_step == 2'd1) begin
            alarm_min_value_next = csmc_pkg::inc_sixty(alarm_min_value);
          end else if (alarm_step == 2'd2) begin
            alarm_hour_value_next = csmc_pkg::inc_capped(alarm_hour_value, 5'd2, 5'd4, 5'd0);
          end
        end
      end
      csmc_pkg::FUNC_CONFIRM: begin
        if (time_step != 3'd0) begin
          job.has_write = 1'b1;
          job.last_idx  = csmc_pkg::IDX_W'(8);
          job.addr[0] = csmc_pkg::WP_ADDR;  job.data[0] = csmc_pkg::WP_OFF;
          job.addr[1] = csmc_pkg::A_SEC;    job.data[1] = clock_sec;
          job.addr[2] = csmc_pkg::A_HOUR;   job.data[2] = clock_hour;
          job.addr[3] = csmc_pkg::A_MIN;    job.data[3] = clock_min;
          job.addr[4] = csmc_pkg::A_WDAY;   job.data[4] = clock_weekday;
          job.addr[5] = csmc_pkg::A_YEAR;   job.data[5] = clock_year;
          job.addr[6] = csmc_pkg::A_MONTH;  job.data[6] = clock_month;
          job.addr[7] = csmc_pkg::A_DAY;    job.data[7] = clock_day;
          job.addr[8] = csmc_pkg::WP_ADDR;  job.data[8] = csmc_pkg::WP_ON;
          time_step_next = 3'd0;
        end else if (alarm_step != 2'd0) begin
          job.has_write = 1'b1;
          job.last_idx  = csmc_pkg::IDX_W'(3);
          job.addr[0] = csmc_pkg::WP_ADDR;  job.data[0] = csmc_pkg::WP_OFF;
          job.addr[1] = csmc_pkg::A_AHOUR;  job.data[1] = alarm_hour_value;
          job.addr[2] = csmc_pkg::A_AMIN;   job.data[2] = alarm_min_value;
          job.addr[3] = csmc_pkg::WP_ADDR;  job.data[3] = csmc_pkg::WP_ON;
          alarm_step_next = 2'd0;
        end
      end
      csmc_pkg::FUNC_ALARM: begin
        if (time_step == 3'd0) begin
          case (alarm_step)
            2'd0: alarm_step_next = 2'd1;
            2'd1: begin
              job = guarded(job, csmc_pkg::A_AMIN, alarm_min_value);
              alarm_step_next = 2'd2;
            end
            default: begin
              job = guarded(job, csmc_pkg::A_AHOUR, alarm_hour_value);
              alarm_step_next = 2'd0;
            end
          endcase
        end
      end
      csmc_pkg::FUNC_REFRESH: begin
        if (time_step == 3'd0 && alarm_step == 2'd0) begin
          clock_sec_next     = sec;
          clock_min_next     = minute;
          clock_hour_next    = hour;
          clock_day_next     = day;
          clock_month_next   = month;
          clock_weekday_next = weekday;
          clock_year_next    = year;
        end
      end
      csmc_pkg::FUNC_ALOAD: begin
        alarm_min_value_next  = minute;
        alarm_hour_value_next = hour;
      end
      default: ;
    endcase

    job.time_stage  = time_step_next;
    job.alarm_stage = alarm_step_next;
    job.alarm_hit   = (clock_hour_next == alarm_hour_value_next) &&
                      (clock_min_next == alarm_min_value_next) &&
                      (clock_sec_next <= 8'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_sec        <= '0;
      clock_min        <= '0;
      clock_hour       <= '0;
      clock_day        <= '0;
      clock_month      <= '0;
      clock_weekday    <= '0;
      clock_year       <= '0;
      alarm_hour_value <= '0;
      alarm_min_value  <= '0;
      time_step        <= '0;
      alarm_step       <= '0;
    end else if (take) begin
      clock_sec        <= clock_sec_next;
      clock_min        <= clock_min_next;
      clock_hour       <= clock_hour_next;
      clock_day        <= clock_day_next;
      clock_month      <= clock_month_next;
      clock_weekday    <= clock_weekday_next;
      clock_year       <= clock_year_next;
      alarm_hour_value <= alarm_hour_value_next;
      alarm_min_value  <= alarm_min_value_next;
      time_step        <= time_step_next;
      alarm_step       <= alarm_step_next;
    end
  end

endmodule

/* hw/rtl/csmc_queue.sv */
module csmc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  csmc_pkg::job_t      wr_job,
  output logic                q_full,
  input  logic                rd_en,
  output csmc_pkg::job_t      rd_job,
  output logic                q_empty
);

  csmc_pkg::job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/csmc_back.sv */
module csmc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  csmc_pkg::job_t                q_job,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic                          has_write,
  output logic [7:0]                    reg_addr,
  output logic [7:0]                    reg_data,
  output logic                          last,
  output logic [2:0]                    time_edit_stage,
  output logic [1:0]                    alarm_edit_stage,
  output logic                          alarm_hit
);

  csmc_pkg::job_t               cur;
  logic                         busy;
  logic [csmc_pkg::IDX_W-1:0]   idx;
  logic                         advance;
  logic                         load;

  assign empty            = !busy;
  assign has_write        = cur.has_write;
  assign reg_addr         = cur.addr[idx];
  assign reg_data         = cur.data[idx];
  assign last             = (idx == cur.last_idx);
  assign time_edit_stage  = cur.time_stage;
  assign alarm_edit_stage = cur.alarm_stage;
  assign alarm_hit        = cur.alarm_hit;

  assign advance = pop && busy;
  assign load    = !busy || (advance && last);
  assign q_pop   = load && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= !q_empty;
      idx  <= '0;
    end else if (advance) begin
      idx <= idx + csmc_pkg::IDX_W'(1);
    end
  end

endmodule

/* hw/rtl/clock_set_mode_controller_core.sv */
// an accepted event's job is queued, then loaded into the back end's job register
// when that frees up; one result beat per cycle while pop is held and jobs wait
// an event gives 1, 3, 4 or 9 result beats, indexed by the back end's beat counter
// the front takes an event per cycle while the two-entry job queue has room
// reset: synchronous; clears time, alarm, edit steps, queue and output state
module clock_set_mode_controller_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] func,
  input  logic [7:0] sec,
  input  logic [7:0] minute,
  input  logic [7:0] hour,
  input  logic [7:0] day,
  input  logic [7:0] month,
  input  logic [7:0] weekday,
  input  logic [7:0] year,
  output logic       empty,
  input  logic       pop,
  output logic       has_write,
  output logic [7:0] reg_addr,
  output logic [7:0] reg_data,
  output logic       last,
  output logic [2:0] time_edit_stage,
  output logic [1:0] alarm_edit_stage,
  output logic       alarm_hit
);

  csmc_pkg::job_t front_job;
  csmc_pkg::job_t head_job;
  logic           take;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  assign full = q_full;
  assign take = push && !q_full;

  csmc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .func    (func),
    .sec     (sec),
    .minute  (minute),
    .hour    (hour),
    .day     (day),
    .month   (month),
    .weekday (weekday),
    .year    (year),
    .job     (front_job)
  );

  csmc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take),
    .wr_job  (front_job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_job  (head_job),
    .q_empty (q_empty)
  );

  csmc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_job            (head_job),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .has_write        (has_write),
    .reg_addr         (reg_addr),
    .reg_data         (reg_data),
    .last             (last),
    .time_edit_stage  (time_edit_stage),
    .alarm_edit_stage (alarm_edit_stage),
    .alarm_hit        (alarm_hit)
  );

endmodule

/* test/csmc_tb_pkg.sv */
package csmc_tb_pkg;

  typedef struct packed {
    csmc_pkg::func_t op;
    logic [7:0] sec;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] weekday;
    logic [7:0] year;
  } clock_event_t;

  typedef struct packed {
    logic       has_write;
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
    logic [2:0] time_stage;
    logic [1:0] alarm_stage;
    logic       hit;
  } write_beat_t;

  // bcd step for seconds and minutes, non-bcd digits roll as plain numbers
  function automatic logic [7:0] bump_sixty(logic [7:0] v);
    int lo;
    int hi;
    lo = int'(v[3:0]) + 1;
    hi = int'(v[7:4]);
    if (lo == 10) begin
      lo = 0;
      hi = (hi + 1 >= 6) ? 0 : hi + 1;
    end
    return 8'(hi * 16 + lo);
  endfunction

  function automatic logic [7:0] bump_capped(logic [7:0] v, int cap_hi, int cap_lo,
                                             int restart);
    int lo;
    int hi;
    lo = int'(v[3:0]) + 1;
    hi = int'(v[7:4]);
    if (hi >= cap_hi && lo >= cap_lo) begin
      lo = restart;
      hi = 0;
    end
    if (lo == 10) begin
      lo = 0;
      hi = hi + 1;
    end
    return 8'(hi * 16 + lo);
  endfunction

  function automatic string beat_str(write_beat_t b);
    return $sformatf("wr=%0b addr=%02h data=%02h last=%0b tstep=%0d astep=%0d hit=%0b",
                     b.has_write, b.addr, b.data, b.last, b.time_stage, b.alarm_stage,
                     b.hit);
  endfunction

  class rtc_write_board;
    logic [7:0]  cur_sec = 8'h00;
    logic [7:0]  cur_min = 8'h00;
    logic [7:0]  cur_hour = 8'h00;
    logic [7:0]  cur_day = 8'h00;
    logic [7:0]  cur_month = 8'h00;
    logic [7:0]  cur_wday = 8'h00;
    logic [7:0]  cur_year = 8'h00;
    logic [7:0]  alarm_hr = 8'h00;
    logic [7:0]  alarm_mn = 8'h00;
    logic [2:0]  time_step = 3'd0;
    logic [1:0]  alarm_step = 2'd0;
    logic [7:0]  wr_addr[$];
    logic [7:0]  wr_data[$];
    write_beat_t due_beats[$];
    int          errors = 0;
    int          beats_checked = 0;
    int          writes_checked = 0;
    int          hits_checked = 0;
    int          events_seen[6] = '{default: 0};

    function void queue_write(logic [7:0] a, logic [7:0] d);
      wr_addr.push_back(a);
      wr_data.push_back(d);
    endfunction

    function void guarded_write(logic [7:0] a, logic [7:0] d);
      queue_write(csmc_pkg::WP_ADDR, csmc_pkg::WP_OFF);
      queue_write(a, d);
      queue_write(csmc_pkg::WP_ADDR, csmc_pkg::WP_ON);
    endfunction

    function void note_event(clock_event_t ev);
      int          nxt;
      int          beats;
      int          i;
      logic        hit_now;
      write_beat_t b;
      wr_addr.delete();
      wr_data.delete();
      events_seen[int'(ev.op)]++;
      case (ev.op)
        csmc_pkg::FUNC_SET: begin
          if (alarm_step == 2'd0) begin
            nxt = int'(time_step) + 1;
            case (nxt)
              2: guarded_write(csmc_pkg::A_SEC, cur_sec);
              3: guarded_write(csmc_pkg::A_MIN, cur_min);
              4: guarded_write(csmc_pkg::A_MONTH, cur_month);
              5: guarded_write(csmc_pkg::A_HOUR, cur_hour);
              6: guarded_write(csmc_pkg::A_DAY, cur_day);
              7: guarded_write(csmc_pkg::A_YEAR, cur_year);
              8: begin
                guarded_write(csmc_pkg::A_WDAY, cur_wday);
                nxt = 0;
              end
              default: ;
            endcase
            time_step = 3'(nxt);
          end
        end
        csmc_pkg::FUNC_ADJUST: begin
          if (time_step != 3'd0 && alarm_step == 2'd0) begin
            case (time_step)
              3'd1: cur_sec = bump_sixty(cur_sec);
              3'd2: cur_min = bump_sixty(cur_min);
              3'd3: cur_hour = bump_capped(cur_hour, 2, 4, 0);
              3'd4: begin
                cur_wday = cur_wday + 8'd1;
                if (cur_wday == 8'd8) begin
                  cur_wday = 8'd1;
                end
              end
              3'd5: cur_day = bump_capped(cur_day, 3, 1, 1);
              3'd6: cur_month = bump_capped(cur_month, 1, 3, 1);
              default: cur_year = bump_capped(cur_year, 2, 1, 1);
            endcase
          end else if (alarm_step != 2'd0 && time_step == 3'd0) begin
            if (alarm_step == 2'd1) begin
              alarm_mn = bump_sixty(alarm_mn);
            end else if (alarm_step == 2'd2) begin
              alarm_hr = bump_capped(alarm_hr, 2, 4, 0);
            end
          end
        end
        csmc_pkg::FUNC_CONFIRM: begin
          if (time_step != 3'd0) begin
            queue_write(csmc_pkg::WP_ADDR, csmc_pkg::WP_OFF);
            queue_write(csmc_pkg::A_SEC, cur_sec);
            queue_write(csmc_pkg::A_HOUR, cur_hour);
            queue_write(csmc_pkg::A_MIN, cur_min);
            queue_write(csmc_pkg::A_WDAY, cur_wday);
            queue_write(csmc_pkg::A_YEAR, cur_year);
            queue_write(csmc_pkg::A_MONTH, cur_month);
            queue_write(csmc_pkg::A_DAY, cur_day);
            queue_write(csmc_pkg::WP_ADDR, csmc_pkg::WP_ON);
            time_step = 3'd0;
          end else if (alarm_step != 2'd0) begin
            queue_write(csmc_pkg::WP_ADDR, csmc_pkg::WP_OFF);
            queue_write(csmc_pkg::A_AHOUR, alarm_hr);
            queue_write(csmc_pkg::A_AMIN, alarm_mn);
            queue_write(csmc_pkg::WP_ADDR, csmc_pkg::WP_ON);
            alarm_step = 2'd0;
          end
        end
        csmc_pkg::FUNC_ALARM: begin
          if (time_step == 3'd0) begin
            nxt = int'(alarm_step) + 1;
            if (nxt == 2) begin
              guarded_write(csmc_pkg::A_AMIN, alarm_mn);
            end else if (nxt >= 3) begin
              guarded_write(csmc_pkg::A_AHOUR, alarm_hr);
              nxt = 0;
            end
            alarm_step = 2'(nxt);
          end
        end
        csmc_pkg::FUNC_REFRESH: begin
          if (time_step == 3'd0 && alarm_step == 2'd0) begin
            cur_sec = ev.sec;
            cur_min = ev.minute;
            cur_hour = ev.hour;
            cur_day = ev.day;
            cur_month = ev.month;
            cur_wday = ev.weekday;
            cur_year = ev.year;
          end
        end
        csmc_pkg::FUNC_ALOAD: begin
          alarm_mn = ev.minute;
          alarm_hr = ev.hour;
        end
        default: ;
      endcase

      hit_now = (cur_hour == alarm_hr) && (cur_min == alarm_mn) && (cur_sec <= 8'd10);
      beats = (wr_addr.size() > 0) ? wr_addr.size() : 1;
      for (i = 0; i < beats; i++) begin
        b.has_write = (wr_addr.size() > 0);
        b.addr = b.has_write ? wr_addr[i] : 8'h00;
        b.data = b.has_write ? wr_data[i] : 8'h00;
        b.last = (i == beats - 1);
        b.time_stage = time_step;
        b.alarm_stage = alarm_step;
        b.hit = hit_now;
        due_beats.push_back(b);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("mismatch: %s", msg);
      end
    endtask

    task check_beat(write_beat_t got);
      write_beat_t want;
      if (due_beats.size() == 0) begin
        report({"beat with nothing pending: ", beat_str(got)});
      end else begin
        want = due_beats.pop_front();
        beats_checked++;
        if (got !== want) begin
          report({"got ", beat_str(got), " want ", beat_str(want)});
        end else begin
          writes_checked += int'(got.has_write);
          hits_checked += int'(got.hit);
        end
      end
    endtask
  endclass

endpackage

/* test/tb_top.sv */
module tb_top;

  localparam int RANDOM_ITEMS = 435;
  localparam int DIRECTED_ITEMS = 25;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 250;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [2:0] func;
  logic [7:0] sec;
  logic [7:0] minute;
  logic [7:0] hour;
  logic [7:0] day;
  logic [7:0] month;
  logic [7:0] weekday;
  logic [7:0] year;
  logic       empty;
  logic       pop;
  logic       has_write;
  logic [7:0] reg_addr;
  logic [7:0] reg_data;
  logic       last;
  logic [2:0] time_edit_stage;
  logic [1:0] alarm_edit_stage;
  logic       alarm_hit;

  csmc_tb_pkg::rtc_write_board board;
  int         items_sent = 0;
  int         burst_left = 0;
  int         quiet_cycles = 0;
  int         rx_cycle = 0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;

  clock_set_mode_controller_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] bcd(int n);
    return 8'((n / 10) * 16 + n % 10);
  endfunction

  function automatic csmc_tb_pkg::clock_event_t build_event(csmc_pkg::func_t op,
                                                            logic [7:0] s, logic [7:0] mi,
                                                            logic [7:0] h, logic [7:0] d,
                                                            logic [7:0] mo, logic [7:0] wd,
                                                            logic [7:0] y);
    csmc_tb_pkg::clock_event_t ev;
    ev.op = op;
    ev.sec = s;
    ev.minute = mi;
    ev.hour = h;
    ev.day = d;
    ev.month = mo;
    ev.weekday = wd;
    ev.year = y;
    return ev;
  endfunction

  function automatic csmc_tb_pkg::clock_event_t random_event(csmc_pkg::func_t op);
    return build_event(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // offer one event, then keep the burst going or drop push for a random gap
  task automatic issue(csmc_tb_pkg::clock_event_t ev);
    int gap;
    push <= 1'b1;
    func <= ev.op;
    sec <= ev.sec;
    minute <= ev.minute;
    hour <= ev.hour;
    day <= ev.day;
    month <= ev.month;
    weekday <= ev.weekday;
    year <= ev.year;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    board.note_event(ev);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 10);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    int         presses;
    int         adjusts;
    int         k;
    logic [7:0] h;
    logic [7:0] m;
    board = new();
    rst = 1'b1;
    push = 1'b0;
    func = 3'd0;
    sec = 8'h00;
    minute = 8'h00;
    hour = 8'h00;
    day = 8'h00;
    month = 8'h00;
    weekday = 8'h00;
    year = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every field at its top bcd value, then walk all seven edit steps with a wrap each
    issue(build_event(csmc_pkg::FUNC_REFRESH, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h07,
                      8'h99));
    repeat (7) begin
      issue(random_event(csmc_pkg::FUNC_SET));
      issue(random_event(csmc_pkg::FUNC_ADJUST));
    end
    issue(random_event(csmc_pkg::FUNC_SET));
    // non-bcd digits everywhere, full confirm, alarm edit with a hit
    issue(build_event(csmc_pkg::FUNC_REFRESH, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                      8'hff));
    issue(random_event(csmc_pkg::FUNC_SET));
    issue(random_event(csmc_pkg::FUNC_ADJUST));
    issue(random_event(csmc_pkg::FUNC_CONFIRM));
    issue(build_event(csmc_pkg::FUNC_ALOAD, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                      8'hff));
    issue(random_event(csmc_pkg::FUNC_ALARM));
    issue(random_event(csmc_pkg::FUNC_ADJUST));
    issue(random_event(csmc_pkg::FUNC_ALARM));
    issue(random_event(csmc_pkg::FUNC_CONFIRM));

    // back-to-back items while the receiver holds off
    hold_req = 1'b1;
    burst_left = 40;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          presses = $urandom_range(1, 8);
          for (k = 0; k < presses; k++) begin
            issue(random_event(csmc_pkg::FUNC_SET));
            adjusts = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 3);
            repeat (adjusts) issue(random_event(csmc_pkg::FUNC_ADJUST));
            if ($urandom_range(0, 7) == 0) begin
              issue(random_event($urandom_range(0, 1) ? csmc_pkg::FUNC_REFRESH
                                                      : csmc_pkg::FUNC_ALARM));
            end
          end
          if ($urandom_range(0, 4) != 0) begin
            issue(random_event(csmc_pkg::FUNC_CONFIRM));
          end
        end
        3, 4: begin
          presses = $urandom_range(1, 3);
          for (k = 0; k < presses; k++) begin
            issue(random_event(csmc_pkg::FUNC_ALARM));
            adjusts = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 3);
            repeat (adjusts) issue(random_event(csmc_pkg::FUNC_ADJUST));
            if ($urandom_range(0, 7) == 0) begin
              issue(random_event($urandom_range(0, 1) ? csmc_pkg::FUNC_REFRESH
                                                      : csmc_pkg::FUNC_SET));
            end
          end
          if (presses < 3 && $urandom_range(0, 4) != 0) begin
            issue(random_event(csmc_pkg::FUNC_CONFIRM));
          end
        end
        5: begin
          // seconds straddle the hit window edge
          h = bcd($urandom_range(0, 23));
          m = bcd($urandom_range(0, 59));
          issue(build_event(csmc_pkg::FUNC_ALOAD, 8'($urandom), m, h, 8'($urandom),
                            8'($urandom), 8'($urandom), 8'($urandom)));
          issue(build_event(csmc_pkg::FUNC_REFRESH, 8'($urandom_range(0, 17)), m, h,
                            bcd($urandom_range(1, 31)), bcd($urandom_range(1, 12)),
                            8'($urandom_range(1, 7)), bcd($urandom_range(0, 99))));
        end
        6: begin
          issue(build_event(csmc_pkg::FUNC_REFRESH, bcd($urandom_range(0, 59)),
                            bcd($urandom_range(0, 59)), bcd($urandom_range(0, 23)),
                            bcd($urandom_range(1, 31)), bcd($urandom_range(1, 12)),
                            8'($urandom_range(1, 7)), bcd($urandom_range(0, 99))));
        end
        default: begin
          issue(random_event(csmc_pkg::func_t'($urandom_range(0, 5))));
        end
      endcase
    end

    push <= 1'b0;
    while (board.due_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("events %0d: set %0d adjust %0d confirm %0d alarm %0d refresh %0d load %0d",
             items_sent, board.events_seen[csmc_pkg::FUNC_SET],
             board.events_seen[csmc_pkg::FUNC_ADJUST],
             board.events_seen[csmc_pkg::FUNC_CONFIRM],
             board.events_seen[csmc_pkg::FUNC_ALARM],
             board.events_seen[csmc_pkg::FUNC_REFRESH],
             board.events_seen[csmc_pkg::FUNC_ALOAD]);
    $display("checked %0d beats, %0d writes, %0d alarm hits, %0d mismatches",
             board.beats_checked, board.writes_checked, board.hits_checked, board.errors);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : receiver
    pop = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ((rx_cycle / 400) % 4)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 1) == 1);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ((rx_cycle % 7) < 3);
        endcase
      end
    end
  end

  // beat taken at the coming edge
  always @(negedge clk) begin
    if (!rst && pop && !empty) begin
      board.check_beat(csmc_tb_pkg::write_beat_t'({has_write, reg_addr, reg_data, last,
                                                   time_edit_stage, alarm_edit_stage,
                                                   alarm_hit}));
    end
  end

  always @(negedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

/* clock_set_mode_controller_core.f */
hw/rtl/csmc_pkg.sv
hw/rtl/csmc_front.sv
hw/rtl/csmc_queue.sv
hw/rtl/csmc_back.sv
hw/rtl/clock_set_mode_controller_core.sv
test/csmc_tb_pkg.sv
test/tb_top.sv
